// File: rtl/cpt_pkg.sv
// Shared widths, region codes and pipeline record types for the closest-point core.
package cpt_pkg;

  localparam int CW  = 32;
  localparam int EW  = CW + 1;
  localparam int PW  = 2 * EW;
  localparam int DW  = PW + 2;
  localparam int HW  = DW / 2;
  localparam int MW  = HW + 1;
  localparam int PPW = 2 * MW;
  localparam int NW  = DW + 2;
  localparam int WW  = 2 * DW;
  localparam int UW  = WW - 4;
  localparam int CH  = EW;
  localparam int NCH = UW / CH;
  localparam int SPW = CH + 1 + EW;
  localparam int SSW = SPW + 1;
  localparam int TW  = UW + EW + 3;
  localparam int QW  = EW + 3;
  localparam int RW  = TW + 4;
  localparam int LAT = QW + 14;
  localparam int NPR = 6;
  localparam int NPP = 4;

  typedef logic [2:0] region_t;

  localparam region_t REG_INTERIOR  = 3'd0;
  localparam region_t REG_EDGE_V1V2 = 3'd1;
  localparam region_t REG_VERT_V2   = 3'd2;
  localparam region_t REG_EDGE_V0V2 = 3'd3;
  localparam region_t REG_VERT_V0   = 3'd4;
  localparam region_t REG_EDGE_V0V1 = 3'd5;
  localparam region_t REG_VERT_V1   = 3'd6;

  typedef enum logic [1:0] {
    K_INT,
    K_EDGE,
    K_S,
    K_T
  } kind_t;

  typedef struct packed {
    logic [2:0][CW-1:0] p0;
    logic [2:0][EW-1:0] e0;
    logic [2:0][EW-1:0] e1;
  } geo_t;

  typedef struct packed {
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] c;
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] e;
    logic signed [NW-1:0] den;
    logic signed [NW-1:0] n1;
    logic signed [NW-1:0] n6;
  } dots_t;

  typedef struct packed {
    region_t region;
    logic    ok;
  } tag_t;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [QW:0]   QOFF = {1'b0, 1'b1, {(QW-1){1'b0}}};

endpackage

// File: rtl/closest_point_on_triangle_core.sv
// Pipelined closest point on a 3-D triangle with region code and degenerate flag.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   input    | start / busy            | in_v0_*, in_v1_*, in_v2_*, in_query_* (xyz)
//   result   | out_valid (strobe)      | out_near_x/y/z, out_region, out_degenerate
//
// One transaction enters every cycle; busy is held low.
// The pipeline is 13 stages of dot products, split 35x35 multiplies,
// region select and clamp, then 36 restoring-division stages, one per quotient bit,
// and an output register.
// rst_n clears only the valid chain; the payload pipeline is not reset.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module closest_point_on_triangle_core
  import cpt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] in_v0_x,
  input  logic signed [CW-1:0] in_v0_y,
  input  logic signed [CW-1:0] in_v0_z,
  input  logic signed [CW-1:0] in_v1_x,
  input  logic signed [CW-1:0] in_v1_y,
  input  logic signed [CW-1:0] in_v1_z,
  input  logic signed [CW-1:0] in_v2_x,
  input  logic signed [CW-1:0] in_v2_y,
  input  logic signed [CW-1:0] in_v2_z,
  input  logic signed [CW-1:0] in_query_x,
  input  logic signed [CW-1:0] in_query_y,
  input  logic signed [CW-1:0] in_query_z,
  output logic                 out_valid,
  output logic signed [CW-1:0] out_near_x,
  output logic signed [CW-1:0] out_near_y,
  output logic signed [CW-1:0] out_near_z,
  output logic [2:0]           out_region,
  output logic                 out_degenerate
);

  logic signed [CW-1:0] vi0 [3];
  logic signed [CW-1:0] vi1 [3];
  logic signed [CW-1:0] vi2 [3];
  logic signed [CW-1:0] vq  [3];

  assign vi0[0] = in_v0_x;
  assign vi0[1] = in_v0_y;
  assign vi0[2] = in_v0_z;
  assign vi1[0] = in_v1_x;
  assign vi1[1] = in_v1_y;
  assign vi1[2] = in_v1_z;
  assign vi2[0] = in_v2_x;
  assign vi2[1] = in_v2_y;
  assign vi2[2] = in_v2_z;
  assign vq[0]  = in_query_x;
  assign vq[1]  = in_query_y;
  assign vq[2]  = in_query_z;

  assign busy = 1'b0;

  logic [LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start};
    end
  end

  geo_t                 g_r [1:12];
  logic signed [EW-1:0] w1_r [3];
  logic signed [PW-1:0] pa_r [3];
  logic signed [PW-1:0] pb_r [3];
  logic signed [PW-1:0] pc_r [3];
  logic signed [PW-1:0] pd_r [3];
  logic signed [PW-1:0] pe_r [3];
  logic signed [DW-1:0] a_r, b_r, c_r, d_r, e_r;
  logic signed [PPW-1:0] pp_r [NPR][NPP];
  dots_t                dt_r [4:6];
  logic signed [WW-1:0] pr_r [NPR];
  logic signed [WW-1:0] det_r, sn_r, tn_r;
  kind_t                kind_r, kind8_r;
  region_t              rg7_r;
  logic signed [WW-1:0] num_r;
  logic [UW-1:0]        den_r, tn7_r, tn8_r, n8_r, dd8_r;
  tag_t                 tag_r [8:12];
  logic [UW-1:0]        ns_r, nt_r;
  logic [UW-1:0]        ddc_r [9:12];
  logic signed [SPW-1:0] ps_r [3][NCH];
  logic signed [SPW-1:0] pt_r [3][NCH];
  logic signed [SSW-1:0] sm_r [3][NCH];
  logic signed [TW-1:0] tot_r [3];
  logic [RW-1:0]        rem_r [QW+1][3];
  logic [QW-1:0]        quo_r [QW+1][3];
  logic [UW-1:0]        dd_r [QW+1];
  logic [2:0][CW-1:0]   dp0_r [QW+1];
  tag_t                 dtag_r [QW+1];
  logic signed [CW-1:0] near_r [3];
  region_t              region_r;
  logic                 degen_r;

  logic signed [EW-1:0] s1e0 [3];
  logic signed [EW-1:0] s1e1 [3];
  logic signed [DW-1:0] mx [NPR];
  logic signed [DW-1:0] my [NPR];
  logic signed [MW-1:0] xh [NPR];
  logic signed [MW-1:0] xl [NPR];
  logic signed [MW-1:0] yh [NPR];
  logic signed [MW-1:0] yl [NPR];
  logic signed [WW-1:0] sum7;
  logic                 gt7;
  region_t              region_nxt;
  kind_t                kind_nxt;
  logic signed [WW-1:0] num_nxt;
  logic [UW-1:0]        den_nxt;
  logic signed [WW-1:0] denw;
  logic                 le0, ge8;
  logic [UW-1:0]        n_nxt, dd_nxt;
  logic [UW-1:0]        ns_nxt, nt_nxt, dd9_nxt;
  logic signed [TW-1:0] tot_nxt [3];
  logic signed [RW-1:0] ddw;
  logic signed [RW-1:0] nq_nxt [3];
  logic [RW-1:0]        dsh [1:QW];
  logic                 qge [1:QW][3];
  logic signed [QW:0]   offs [3];
  logic signed [QW+1:0] sumr [3];
  logic signed [CW-1:0] near_nxt [3];

  // edges, products, dot sums and split partial products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s1e0[k] = $signed(g_r[1].e0[k]);
      s1e1[k] = $signed(g_r[1].e1[k]);
    end
    mx[0] = a_r; my[0] = c_r;
    mx[1] = b_r; my[1] = b_r;
    mx[2] = b_r; my[2] = e_r;
    mx[3] = c_r; my[3] = d_r;
    mx[4] = b_r; my[4] = d_r;
    mx[5] = a_r; my[5] = e_r;
    for (int m = 0; m < NPR; m++) begin
      xh[m] = MW'($signed(mx[m][DW-1:HW]));
      xl[m] = $signed({1'b0, mx[m][HW-1:0]});
      yh[m] = MW'($signed(my[m][DW-1:HW]));
      yl[m] = $signed({1'b0, my[m][HW-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      g_r[1].p0[k] <= vi0[k];
      g_r[1].e0[k] <= EW'(vi1[k]) - EW'(vi0[k]);
      g_r[1].e1[k] <= EW'(vi2[k]) - EW'(vi0[k]);
      w1_r[k]      <= EW'(vi0[k]) - EW'(vq[k]);
      pa_r[k] <= s1e0[k] * s1e0[k];
      pb_r[k] <= s1e0[k] * s1e1[k];
      pc_r[k] <= s1e1[k] * s1e1[k];
      pd_r[k] <= s1e0[k] * w1_r[k];
      pe_r[k] <= s1e1[k] * w1_r[k];
    end
    for (int s = 2; s <= 12; s++) begin
      g_r[s] <= g_r[s-1];
    end
    a_r <= DW'(pa_r[0]) + DW'(pa_r[1]) + DW'(pa_r[2]);
    b_r <= DW'(pb_r[0]) + DW'(pb_r[1]) + DW'(pb_r[2]);
    c_r <= DW'(pc_r[0]) + DW'(pc_r[1]) + DW'(pc_r[2]);
    d_r <= DW'(pd_r[0]) + DW'(pd_r[1]) + DW'(pd_r[2]);
    e_r <= DW'(pe_r[0]) + DW'(pe_r[1]) + DW'(pe_r[2]);
    for (int m = 0; m < NPR; m++) begin
      pp_r[m][0] <= xh[m] * yh[m];
      pp_r[m][1] <= xh[m] * yl[m];
      pp_r[m][2] <= xl[m] * yh[m];
      pp_r[m][3] <= xl[m] * yl[m];
      pr_r[m] <= (WW'(pp_r[m][0]) <<< (2 * HW))
               + ((WW'(pp_r[m][1]) + WW'(pp_r[m][2])) <<< HW)
               + WW'(pp_r[m][3]);
    end
    dt_r[4].a   <= a_r;
    dt_r[4].c   <= c_r;
    dt_r[4].d   <= d_r;
    dt_r[4].e   <= e_r;
    dt_r[4].den <= NW'(a_r) + NW'(c_r) - (NW'(b_r) <<< 1);
    dt_r[4].n1  <= NW'(c_r) + NW'(e_r) - NW'(b_r) - NW'(d_r);
    dt_r[4].n6  <= NW'(a_r) + NW'(d_r) - NW'(b_r) - NW'(e_r);
    dt_r[5] <= dt_r[4];
    dt_r[6] <= dt_r[5];
    det_r <= pr_r[0] - pr_r[1];
    sn_r  <= pr_r[2] - pr_r[3];
    tn_r  <= pr_r[4] - pr_r[5];
  end

  // region select
  always_comb begin
    sum7 = sn_r + tn_r;
    gt7  = det_r > sum7;
    if (gt7) begin
      if (sn_r[WW-1]) begin
        region_nxt = tn_r[WW-1] ? REG_VERT_V0 : REG_EDGE_V0V2;
      end else begin
        region_nxt = tn_r[WW-1] ? REG_EDGE_V0V1 : REG_INTERIOR;
      end
    end else begin
      if (sn_r[WW-1]) begin
        region_nxt = REG_VERT_V2;
      end else begin
        region_nxt = tn_r[WW-1] ? REG_VERT_V1 : REG_EDGE_V1V2;
      end
    end
    unique case (region_nxt)
      REG_INTERIOR:  kind_nxt = K_INT;
      REG_EDGE_V1V2: kind_nxt = K_EDGE;
      REG_VERT_V2:   kind_nxt = (dt_r[6].n1 > 0) ? K_EDGE : K_T;
      REG_EDGE_V0V2: kind_nxt = K_T;
      REG_VERT_V0:   kind_nxt = dt_r[6].d[DW-1] ? K_S : K_T;
      REG_EDGE_V0V1: kind_nxt = K_S;
      REG_VERT_V1:   kind_nxt = (dt_r[6].n6 > 0) ? K_EDGE : K_S;
      default:       kind_nxt = K_INT;
    endcase
    case (kind_nxt)
      K_EDGE: begin
        num_nxt = WW'(dt_r[6].n1);
        den_nxt = UW'(dt_r[6].den);
      end
      K_S: begin
        num_nxt = -WW'(dt_r[6].d);
        den_nxt = UW'(dt_r[6].a);
      end
      K_T: begin
        num_nxt = -WW'(dt_r[6].e);
        den_nxt = UW'(dt_r[6].c);
      end
      default: begin
        num_nxt = sn_r;
        den_nxt = det_r[UW-1:0];
      end
    endcase
  end

  // clamp to [0,1] and form the two weights
  always_comb begin
    denw = $signed({{(WW-UW){1'b0}}, den_r});
    le0  = num_r <= 0;
    ge8  = num_r >= denw;
    if (kind_r == K_INT) begin
      n_nxt  = num_r[UW-1:0];
      dd_nxt = den_r;
    end else if (le0) begin
      n_nxt  = '0;
      dd_nxt = UW'(1);
    end else if (ge8) begin
      n_nxt  = UW'(1);
      dd_nxt = UW'(1);
    end else begin
      n_nxt  = num_r[UW-1:0];
      dd_nxt = den_r;
    end
    dd9_nxt = dd8_r;
    case (kind8_r)
      K_EDGE: begin
        ns_nxt = n8_r;
        nt_nxt = dd8_r - n8_r;
      end
      K_S: begin
        ns_nxt = n8_r;
        nt_nxt = '0;
      end
      K_T: begin
        ns_nxt = '0;
        nt_nxt = n8_r;
      end
      default: begin
        ns_nxt = n8_r;
        nt_nxt = tn8_r;
      end
    endcase
    if (!tag_r[8].ok) begin
      ns_nxt  = '0;
      nt_nxt  = '0;
      dd9_nxt = UW'(1);
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    rg7_r  <= region_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    tn7_r  <= tn_r[UW-1:0];
    n8_r    <= n_nxt;
    dd8_r   <= dd_nxt;
    kind8_r <= kind_r;
    tn8_r   <= tn7_r;
    tag_r[8].region <= rg7_r;
    tag_r[8].ok     <= |den_r;
    for (int s = 9; s <= 12; s++) begin
      tag_r[s] <= tag_r[s-1];
    end
    ns_r     <= ns_nxt;
    nt_r     <= nt_nxt;
    ddc_r[9] <= dd9_nxt;
    for (int s = 10; s <= 12; s++) begin
      ddc_r[s] <= ddc_r[s-1];
    end
  end

  // weighted offset numerators
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tot_nxt[k] = '0;
      for (int j = 0; j < NCH; j++) begin
        tot_nxt[k] = tot_nxt[k] + (TW'(sm_r[k][j]) <<< (CH * j));
      end
    end
    ddw = $signed({{(RW-UW){1'b0}}, ddc_r[12]});
    for (int k = 0; k < 3; k++) begin
      nq_nxt[k] = (RW'(tot_r[k]) <<< 1) + ddw + (ddw <<< QW);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < NCH; j++) begin
        ps_r[k][j] <= $signed({1'b0, ns_r[j*CH +: CH]}) * $signed(g_r[9].e0[k]);
        pt_r[k][j] <= $signed({1'b0, nt_r[j*CH +: CH]}) * $signed(g_r[9].e1[k]);
        sm_r[k][j] <= SSW'(ps_r[k][j]) + SSW'(pt_r[k][j]);
      end
      tot_r[k] <= tot_nxt[k];
    end
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    for (int t = 1; t <= QW; t++) begin
      dsh[t] = RW'(dd_r[t-1]) << (QW - t + 1);
      for (int k = 0; k < 3; k++) begin
        qge[t][k] = rem_r[t-1][k] >= dsh[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      rem_r[0][k] <= nq_nxt[k];
      quo_r[0][k] <= '0;
    end
    dd_r[0]   <= ddc_r[12];
    dp0_r[0]  <= g_r[12].p0;
    dtag_r[0] <= tag_r[12];
    for (int t = 1; t <= QW; t++) begin
      dd_r[t]   <= dd_r[t-1];
      dp0_r[t]  <= dp0_r[t-1];
      dtag_r[t] <= dtag_r[t-1];
      for (int k = 0; k < 3; k++) begin
        rem_r[t][k] <= qge[t][k] ? (rem_r[t-1][k] - dsh[t]) : rem_r[t-1][k];
        quo_r[t][k] <= quo_r[t-1][k] | (QW'(qge[t][k]) << (QW - t));
      end
    end
  end

  // add offset to vertex zero and saturate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      offs[k] = $signed({1'b0, quo_r[QW][k]}) - QOFF;
      sumr[k] = (QW+2)'($signed(dp0_r[QW][k])) + (QW+2)'(offs[k]);
      if (sumr[k] > (QW+2)'(CMAX)) begin
        near_nxt[k] = CMAX;
      end else if (sumr[k] < (QW+2)'(CMIN)) begin
        near_nxt[k] = CMIN;
      end else begin
        near_nxt[k] = sumr[k][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      near_r[k] <= near_nxt[k];
    end
    region_r <= dtag_r[QW].region;
    degen_r  <= !dtag_r[QW].ok;
  end

  assign out_valid      = vld_r[LAT-1];
  assign out_near_x     = near_r[0];
  assign out_near_y     = near_r[1];
  assign out_near_z     = near_r[2];
  assign out_region     = region_r;
  assign out_degenerate = degen_r;

`ifndef SYNTHESIS
  a_valid_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result strobe without a matching transaction");

  a_region_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_region <= REG_VERT_V1))
    else $error("region code out of range");

  a_degenerate_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_near_x == $past(in_v0_x, LAT) && out_near_y == $past(in_v0_y, LAT) &&
       out_near_z == $past(in_v0_z, LAT)))
    else $error("degenerate result is not vertex zero");
`endif

endmodule
